>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// check an implication in the next cycle
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/bra_pkg.sv
package bra_pkg;

	localparam int MAP_BYTES_DEF = 128;
	localparam int BYTE_BITS     = 8;
	localparam int TYPE_W        = 2;
	localparam int IDX_W         = 32;
	localparam int RUN_W         = 11;
	localparam int ST_W          = 2;
	localparam int LEN_W         = 8;
	localparam int CFG_IDX_W     = 4;
	localparam int CFG_DATA_W    = 32;

	localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_TEST  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BASE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_LEN    = 4'd1;

	localparam logic [LEN_W-1:0] MAP_LEN_RST = 8'd128;

	typedef struct packed {
		logic             scan;
		logic             test;
		logic             upd;
		logic             val;
		logic [RUN_W-1:0] count;
	} cmd_t;

endpackage

>>> rtl/bra_req_if.sv
interface bra_req_if;
	import bra_pkg::*;

	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] req_type;
	logic [IDX_W-1:0]  bit_index;
	logic              bit_value_in;
	logic [RUN_W-1:0]  run_length;

	modport source (output valid, req_type, bit_index, bit_value_in, run_length, input ready);
	modport sink (input valid, req_type, bit_index, bit_value_in, run_length, output ready);
endinterface

>>> rtl/bra_rsp_if.sv
interface bra_rsp_if;
	import bra_pkg::*;

	logic             valid;
	logic             ready;
	logic [ST_W-1:0]  status;
	logic             bit_value_out;
	logic [IDX_W-1:0] run_start;

	modport source (output valid, status, bit_value_out, run_start, input ready);
	modport sink (input valid, status, bit_value_out, run_start, output ready);
endinterface

>>> rtl/bra_cfg_if.sv
interface bra_cfg_if;
	import bra_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/bra_cell.sv
module bra_cell #(
	parameter int MAP_BYTES = bra_pkg::MAP_BYTES_DEF,
	parameter int IDX       = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bra_pkg::cmd_t                    cmd,
	input  logic [$clog2(MAP_BYTES+1)-1:0]   used,
	input  logic [$clog2(MAP_BYTES*8)-1:0]   lo,
	input  logic [$clog2(MAP_BYTES*8)-1:0]   hi,
	input  logic                             tin_vld,
	input  logic                             tin_hit,
	input  logic [bra_pkg::RUN_W-1:0]        tin_run,
	input  logic [$clog2(MAP_BYTES*8)-1:0]   tin_pos,
	output logic                             tout_vld,
	output logic                             tout_hit,
	output logic [bra_pkg::RUN_W-1:0]        tout_run,
	output logic [$clog2(MAP_BYTES*8)-1:0]   tout_pos
);
	import bra_pkg::*;

	localparam int POS_W = $clog2(MAP_BYTES*8);

	logic [BYTE_BITS-1:0] map_q;
	logic                 vld_q;
	logic                 hit_q;
	logic [RUN_W-1:0]     run_q;
	logic [POS_W-1:0]     pos_q;
	logic                 active;
	logic                 hit;
	logic [RUN_W-1:0]     run;
	logic [POS_W-1:0]     pos;

	assign active = (IDX < int'(used));

	always_comb begin
		run = tin_run;
		hit = tin_hit;
		pos = tin_pos;
		if (cmd.scan && active && !tin_hit) begin
			for (int j = 0; j < BYTE_BITS; j++) begin
				if (!hit) begin
					run = map_q[j] ? '0 : run + RUN_W'(1);
					if (run == cmd.count) begin
						hit = 1'b1;
						pos = POS_W'(IDX * BYTE_BITS + j);
					end
				end
			end
		end
		if (cmd.test && ((lo >> 3) == POS_W'(IDX))) begin
			hit = map_q[lo[2:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (cmd.upd) begin
			for (int j = 0; j < BYTE_BITS; j++) begin
				if ((POS_W'(IDX * BYTE_BITS + j) >= lo) && (POS_W'(IDX * BYTE_BITS + j) <= hi)) begin
					map_q[j] <= cmd.val;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tin_vld;
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= hit;
		run_q <= run;
		pos_q <= pos;
	end

	assign tout_vld = vld_q;
	assign tout_hit = hit_q;
	assign tout_run = run_q;
	assign tout_pos = pos_q;

endmodule

>>> rtl/bra_ctrl.sv
module bra_ctrl #(
	parameter int MAP_BYTES = bra_pkg::MAP_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	bra_req_if.sink                          req,
	bra_rsp_if.source                        rsp,
	bra_cfg_if.sink                          cfg,
	output bra_pkg::cmd_t                    cmd,
	output logic [$clog2(MAP_BYTES+1)-1:0]   used,
	output logic [$clog2(MAP_BYTES*8)-1:0]   lo,
	output logic [$clog2(MAP_BYTES*8)-1:0]   hi,
	output logic                             launch,
	input  logic                             tail_vld,
	input  logic                             tail_hit,
	input  logic [$clog2(MAP_BYTES*8)-1:0]   tail_pos
);
	import bra_pkg::*;

	localparam int POS_W = $clog2(MAP_BYTES*8);
	localparam int UB_W  = $clog2(MAP_BYTES+1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] base_q;
	logic [LEN_W-1:0] len_q;
	logic             launch_q;
	logic             scan_q;
	logic             test_q;
	logic             val_q;
	logic [RUN_W-1:0] count_q;
	logic [POS_W-1:0] lo_q;
	logic [POS_W-1:0] hi_q;
	logic [ST_W-1:0]  res_st_q;
	logic             res_bv_q;
	logic [IDX_W-1:0] res_rs_q;
	logic             ov_q;
	logic [ST_W-1:0]  ost_q;
	logic             obv_q;
	logic [IDX_W-1:0] ors_q;
	logic [IDX_W-1:0] rel;
	logic             in_rng;
	logic [POS_W-1:0] start;

	always_comb begin
		if (32'(len_q) > 32'(MAP_BYTES)) begin
			used = UB_W'(MAP_BYTES);
		end else begin
			used = UB_W'(len_q);
		end
	end

	assign rel    = req.bit_index - base_q;
	assign in_rng = (req.bit_index >= base_q) && (rel[IDX_W-1:3] < (IDX_W-3)'(used));
	assign start  = tail_pos + POS_W'(1) - POS_W'(count_q);

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign cmd.scan  = scan_q;
	assign cmd.test  = test_q;
	assign cmd.upd   = (state_q == S_UPD);
	assign cmd.val   = val_q;
	assign cmd.count = count_q;
	assign lo        = lo_q;
	assign hi        = hi_q;
	assign launch    = launch_q;

	assign rsp.valid         = ov_q;
	assign rsp.status        = ost_q;
	assign rsp.bit_value_out = obv_q;
	assign rsp.run_start     = ors_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			len_q  <= MAP_LEN_RST;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_INDEX_BASE) begin
				base_q <= cfg.data;
			end else if (cfg.index == CFG_MAP_LEN) begin
				len_q <= cfg.data[LEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			launch_q <= 1'b0;
			scan_q   <= 1'b0;
			test_q   <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			if (ov_q && rsp.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						scan_q <= 1'b0;
						test_q <= 1'b0;
						state_q <= S_DONE;
						case (req.req_type)
							REQ_ALLOC: begin
								if (req.run_length != '0) begin
									scan_q   <= 1'b1;
									launch_q <= 1'b1;
									state_q  <= S_SCAN;
								end
							end
							REQ_WRITE: begin
								if (in_rng) begin
									state_q <= S_UPD;
								end
							end
							REQ_TEST: begin
								if (in_rng) begin
									test_q   <= 1'b1;
									launch_q <= 1'b1;
									state_q  <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (tail_vld) begin
						if (scan_q && tail_hit) begin
							state_q <= S_UPD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_UPD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!ov_q || rsp.ready) begin
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			count_q  <= req.run_length;
			val_q    <= req.bit_value_in;
			lo_q     <= rel[POS_W-1:0];
			hi_q     <= rel[POS_W-1:0];
			res_bv_q <= 1'b0;
			res_rs_q <= '0;
			case (req.req_type) inside
				REQ_ALLOC: res_st_q <= ST_NOT_FOUND;
				REQ_WRITE, REQ_TEST: res_st_q <= in_rng ? ST_OK : ST_RANGE;
				default: res_st_q <= ST_RANGE;
			endcase
		end
		if (state_q == S_SCAN && tail_vld) begin
			if (scan_q) begin
				if (tail_hit) begin
					lo_q     <= start;
					hi_q     <= tail_pos;
					val_q    <= 1'b1;
					res_st_q <= ST_OK;
					res_rs_q <= base_q + IDX_W'(start);
				end
			end else begin
				res_bv_q <= tail_hit;
			end
		end
		if (state_q == S_DONE && (!ov_q || rsp.ready)) begin
			ost_q <= res_st_q;
			obv_q <= res_bv_q;
			ors_q <= res_rs_q;
		end
	end

endmodule

>>> rtl/bitmap_run_allocator.sv
// First-fit bit map allocator. The map is a chain of MAP_BYTES cells, one map byte
// in each; all bits are free after reset. An allocate or test request sends a scan
// word down the whole chain, one cell per cycle, so every scan passes all MAP_BYTES
// cells, whatever the used map length; an allocate that finds a run goes on to the
// update state to mark it, a write goes there at once, and a request that fails its
// checks goes straight to the result. One request is in work at a time; the next one
// is taken while the previous result waits in the output register.
module bitmap_run_allocator #(
	parameter int MAP_BYTES = bra_pkg::MAP_BYTES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	bra_req_if.sink   req,
	bra_rsp_if.source rsp,
	bra_cfg_if.sink   cfg
);
	import bra_pkg::*;

	localparam int POS_W = $clog2(MAP_BYTES*8);
	localparam int UB_W  = $clog2(MAP_BYTES+1);

	cmd_t             cmd;
	logic [UB_W-1:0]  used;
	logic [POS_W-1:0] lo;
	logic [POS_W-1:0] hi;
	logic             launch;
	logic             tok_vld [MAP_BYTES+1];
	logic             tok_hit [MAP_BYTES+1];
	logic [RUN_W-1:0] tok_run [MAP_BYTES+1];
	logic [POS_W-1:0] tok_pos [MAP_BYTES+1];

	assign tok_vld[0] = launch;
	assign tok_hit[0] = 1'b0;
	assign tok_run[0] = '0;
	assign tok_pos[0] = '0;

	bra_ctrl #(.MAP_BYTES(MAP_BYTES)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg      (cfg),
		.cmd      (cmd),
		.used     (used),
		.lo       (lo),
		.hi       (hi),
		.launch   (launch),
		.tail_vld (tok_vld[MAP_BYTES]),
		.tail_hit (tok_hit[MAP_BYTES]),
		.tail_pos (tok_pos[MAP_BYTES])
	);

	for (genvar k = 0; k < MAP_BYTES; k++) begin : g_cell
		bra_cell #(.MAP_BYTES(MAP_BYTES), .IDX(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.used     (used),
			.lo       (lo),
			.hi       (hi),
			.tin_vld  (tok_vld[k]),
			.tin_hit  (tok_hit[k]),
			.tin_run  (tok_run[k]),
			.tin_pos  (tok_pos[k]),
			.tout_vld (tok_vld[k+1]),
			.tout_hit (tok_hit[k+1]),
			.tout_run (tok_run[k+1]),
			.tout_pos (tok_pos[k+1])
		);
	end

endmodule

>>> rtl/bra_checker.sv
`include "assert_macros.svh"

module bra_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [bra_pkg::ST_W-1:0]   rsp_status,
	input logic                       rsp_bit_value_out,
	input logic [bra_pkg::IDX_W-1:0]  rsp_run_start
);
	import bra_pkg::*;

	`ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_run_start))
	`ASSERT_NXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready)
	`ASSERT_IMP(a_fail_zero, clk, arst_n, rsp_valid && (rsp_status != ST_OK), (rsp_run_start == '0) && !rsp_bit_value_out)
	`ASSERT_IMP(a_bit_only_ok, clk, arst_n, rsp_valid && rsp_bit_value_out, (rsp_status == ST_OK) && (rsp_run_start == '0))

endmodule

bind bitmap_run_allocator bra_checker u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_bit_value_out (rsp.bit_value_out),
	.rsp_run_start     (rsp.run_start)
);

>>> bench/tb_bitmap_run_allocator.sv
module tb_bitmap_run_allocator;
	import bra_pkg::*;

	localparam int MAP_BYTES = MAP_BYTES_DEF;
	localparam logic [TYPE_W-1:0] REQ_BAD = 2'd3;
	localparam int ROWS = 22;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 210;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic             vout;
		logic [IDX_W-1:0] start;
	} reply_t;

	typedef struct packed {
		logic [TYPE_W-1:0] ty;
		logic [IDX_W-1:0]  idx;
		logic              v;
		logic [RUN_W-1:0]  n;
		bit                typed;
		reply_t            want;
	} row_t;

	typedef struct packed {
		logic [IDX_W-1:0] start;
		logic [RUN_W-1:0] n;
	} span_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] base;
		logic [LEN_W-1:0]      len;
		bit                    rand_base;
		bit                    idle;
	} setting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bra_req_if req_if();
	bra_rsp_if rsp_if();
	bra_cfg_if cfg_if();

	bitmap_run_allocator #(.MAP_BYTES(MAP_BYTES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	logic [MAP_BYTES*8-1:0] unit_map = '0;
	logic [IDX_W-1:0]       base_reg = '0;
	logic [LEN_W-1:0]       len_reg = MAP_LEN_RST;

	reply_t owed_replies[$];
	span_t  live_runs[$];

	bit req_idle_on = 1'b1;
	bit rsp_idle_on = 1'b1;
	int unsigned stall_left = 0;
	int unsigned words_sent = 0;
	int unsigned bad_count = 0;
	int unsigned n_granted = 0;
	int unsigned n_refused = 0;
	int unsigned n_range = 0;

	row_t directed_rows[ROWS] = '{
		'{REQ_TEST,  32'd0,        1'b0, 11'd0,    1'b1, '{ST_OK,        1'b0, 32'd0}},
		'{REQ_ALLOC, 32'd0,        1'b0, 11'd0,    1'b1, '{ST_NOT_FOUND, 1'b0, 32'd0}},
		'{REQ_ALLOC, 32'hFFFFFFFF, 1'b1, 11'd1024, 1'b1, '{ST_OK,        1'b0, 32'd0}},
		'{REQ_ALLOC, 32'd0,        1'b0, 11'd1,    1'b1, '{ST_NOT_FOUND, 1'b0, 32'd0}},
		'{REQ_TEST,  32'd1023,     1'b0, 11'd0,    1'b1, '{ST_OK,        1'b1, 32'd0}},
		'{REQ_TEST,  32'd1024,     1'b1, 11'h7FF,  1'b1, '{ST_RANGE,     1'b0, 32'd0}},
		'{REQ_WRITE, 32'd1023,     1'b0, 11'd0,    1'b1, '{ST_OK,        1'b0, 32'd0}},
		'{REQ_TEST,  32'd1023,     1'b0, 11'd0,    1'b1, '{ST_OK,        1'b0, 32'd0}},
		'{REQ_ALLOC, 32'd0,        1'b0, 11'd1,    1'b1, '{ST_OK,        1'b0, 32'd1023}},
		'{REQ_ALLOC, 32'd0,        1'b0, 11'h7FF,  1'b1, '{ST_NOT_FOUND, 1'b0, 32'd0}},
		'{REQ_WRITE, 32'hFFFFFFFF, 1'b1, 11'd0,    1'b1, '{ST_RANGE,     1'b0, 32'd0}},
		'{REQ_TEST,  32'hFFFFFFFF, 1'b0, 11'd0,    1'b1, '{ST_RANGE,     1'b0, 32'd0}},
		'{REQ_BAD,   32'd5,        1'b1, 11'd3,    1'b1, '{ST_RANGE,     1'b0, 32'd0}},
		'{REQ_WRITE, 32'd7,        1'b0, 11'd0,    1'b1, '{ST_OK,        1'b0, 32'd0}},
		'{REQ_WRITE, 32'd8,        1'b0, 11'd0,    1'b1, '{ST_OK,        1'b0, 32'd0}},
		'{REQ_ALLOC, 32'd0,        1'b0, 11'd2,    1'b1, '{ST_OK,        1'b0, 32'd7}},
		'{REQ_WRITE, 32'd0,        1'b0, 11'd9,    1'b0, '0},
		'{REQ_WRITE, 32'd1,        1'b0, 11'd0,    1'b0, '0},
		'{REQ_ALLOC, 32'd0,        1'b0, 11'd3,    1'b0, '0},
		'{REQ_TEST,  32'd7,        1'b0, 11'd0,    1'b0, '0},
		'{REQ_WRITE, 32'd2,        1'b1, 11'd0,    1'b0, '0},
		'{REQ_ALLOC, 32'd0,        1'b1, 11'd1,    1'b0, '0}
	};

	setting_t settings[PHASES] = '{
		'{32'h0,         8'd32,  1'b0, 1'b1},
		'{32'hFFFF_FFF0, 8'd4,   1'b0, 1'b1},
		'{32'h0,         8'd1,   1'b1, 1'b1},
		'{32'hFFFF_FFFF, 8'd0,   1'b0, 1'b1},
		'{32'h0,         8'd128, 1'b1, 1'b1},
		'{32'h0,         8'd255, 1'b0, 1'b1},
		'{32'h0,         8'd12,  1'b1, 1'b1},
		'{32'd200,       8'd16,  1'b0, 1'b0}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned used_bytes();
		return (32'(len_reg) > MAP_BYTES) ? MAP_BYTES : 32'(len_reg);
	endfunction

	function automatic bit in_map(input logic [IDX_W-1:0] idx, output int unsigned pos);
		logic [IDX_W-1:0] rel;
		pos = 0;
		if (idx < base_reg)
			return 1'b0;
		rel = idx - base_reg;
		if ((rel >> 3) >= used_bytes())
			return 1'b0;
		pos = rel;
		return 1'b1;
	endfunction

	function automatic reply_t allocator_reply(input logic [TYPE_W-1:0] ty,
			input logic [IDX_W-1:0] idx, input logic v, input logic [RUN_W-1:0] n);
		reply_t r;
		int unsigned total;
		int unsigned run;
		int unsigned start;
		int unsigned pos;
		int unsigned i;
		bit found;
		r = '0;
		r.status = ST_RANGE;
		found = 1'b0;
		start = 0;
		case (ty)
			REQ_ALLOC: begin
				r.status = ST_NOT_FOUND;
				total = used_bytes() * 8;
				run = 0;
				if (n != '0) begin
					for (i = 0; i < total; i++) begin
						run = unit_map[i] ? 0 : run + 1;
						if (run == 32'(n)) begin
							start = i + 1 - 32'(n);
							found = 1'b1;
							break;
						end
					end
				end
				if (found) begin
					for (i = 0; i < 32'(n); i++)
						unit_map[start + i] = 1'b1;
					r.status = ST_OK;
					r.start = start + base_reg;
				end
			end
			REQ_WRITE: begin
				if (in_map(idx, pos)) begin
					unit_map[pos] = v;
					r.status = ST_OK;
				end
			end
			REQ_TEST: begin
				if (in_map(idx, pos)) begin
					r.vout = unit_map[pos];
					r.status = ST_OK;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		int unsigned cap;
		int unsigned sel;
		cap = used_bytes();
		sel = $urandom_range(0, 99);
		if (cap != 0 && sel < 80)
			return base_reg + $urandom_range(0, cap * 8 - 1);
		if (sel < 88)
			return base_reg - 1;
		if (sel < 94)
			return base_reg + cap * 8;
		return $urandom;
	endfunction

	function automatic logic [RUN_W-1:0] pick_length();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 85)
			return RUN_W'($urandom_range(1, 8));
		if (sel < 95)
			return RUN_W'($urandom_range(9, 64));
		if (sel < 99)
			return RUN_W'($urandom_range(65, 1024));
		return RUN_W'($urandom_range(0, 2047));
	endfunction

	task automatic send_req(input logic [TYPE_W-1:0] ty, input logic [IDX_W-1:0] idx,
			input logic v, input logic [RUN_W-1:0] n, input bit typed, input reply_t want);
		reply_t r;
		if (req_idle_on && $urandom_range(0, 5) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.req_type <= ty;
		req_if.bit_index <= idx;
		req_if.bit_value_in <= v;
		req_if.run_length <= n;
		do @(posedge clk); while (!req_if.ready);
		r = allocator_reply(ty, idx, v, n);
		owed_replies.push_back(typed ? want : r);
		words_sent++;
		if (ty == REQ_ALLOC && r.status == ST_OK && n <= 16)
			live_runs.push_back('{r.start, n});
	endtask

	task automatic free_run(input logic [IDX_W-1:0] start, input int unsigned n);
		for (int unsigned k = 0; k < n; k++)
			send_req(REQ_WRITE, start + k, 1'b0, RUN_W'($urandom), 1'b0, '0);
	endtask

	task automatic settle();
		req_if.valid <= 1'b0;
		while (owed_replies.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input logic [CFG_DATA_W-1:0] d);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= r;
		cfg_if.data <= d;
		do @(posedge clk); while (!cfg_if.ready);
		if (r == CFG_INDEX_BASE)
			base_reg = d;
		else if (r == CFG_MAP_LEN)
			len_reg = d[LEN_W-1:0];
	endtask

	task automatic random_word();
		int unsigned pick;
		int unsigned k;
		span_t s;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			send_req(REQ_ALLOC, $urandom, 1'($urandom), pick_length(), 1'b0, '0);
		end else if (pick < 50 && live_runs.size() != 0) begin
			k = $urandom_range(0, live_runs.size() - 1);
			s = live_runs[k];
			live_runs.delete(k);
			free_run(s.start, s.n);
		end else if (pick < 75) begin
			send_req(REQ_WRITE, pick_index(), 1'($urandom), RUN_W'($urandom), 1'b0, '0);
		end else if (pick < 97) begin
			send_req(REQ_TEST, pick_index(), 1'($urandom), RUN_W'($urandom), 1'b0, '0);
		end else begin
			send_req(REQ_BAD, $urandom, 1'($urandom), RUN_W'($urandom), 1'b0, '0);
		end
	endtask

	task automatic check_reply();
		reply_t want;
		if (owed_replies.size() == 0) begin
			bad_count++;
			if (bad_count <= 10)
				$display("%0t: reply with none owed: status %0d vout %0d start %h", $realtime,
					rsp_if.status, rsp_if.bit_value_out, rsp_if.run_start);
			return;
		end
		want = owed_replies.pop_front();
		case (want.status)
			ST_OK: n_granted++;
			ST_NOT_FOUND: n_refused++;
			default: n_range++;
		endcase
		if (rsp_if.status !== want.status || rsp_if.bit_value_out !== want.vout
				|| rsp_if.run_start !== want.start) begin
			bad_count++;
			if (bad_count <= 10)
				$display("%0t: mismatch: status %0d/%0d vout %0d/%0d start %h/%h (exp/got)",
					$realtime, want.status, rsp_if.status, want.vout, rsp_if.bit_value_out,
					want.start, rsp_if.run_start);
		end
	endtask

	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready)
				check_reply();
			if (stall_left == 0 && rsp_idle_on && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 12);
			if (stall_left != 0) begin
				rsp_if.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		#30_000_000;
		$display("tb_bitmap_run_allocator: done, errors");
		$finish;
	end

	initial begin
		int unsigned phase_end;
		setting_t s;
		req_if.valid <= 1'b0;
		req_if.req_type <= REQ_ALLOC;
		req_if.bit_index <= '0;
		req_if.bit_value_in <= 1'b0;
		req_if.run_length <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= CFG_INDEX_BASE;
		cfg_if.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < ROWS; r++)
			send_req(directed_rows[r].ty, directed_rows[r].idx, directed_rows[r].v,
				directed_rows[r].n, directed_rows[r].typed, directed_rows[r].want);

		for (int p = 0; p < PHASES; p++) begin
			s = settings[p];
			if (s.rand_base)
				s.base = $urandom;
			if (p == 6)
				s.len = LEN_W'($urandom_range(1, 32));
			settle();
			write_reg(CFG_INDEX_BASE, s.base);
			write_reg(CFG_MAP_LEN, {{(CFG_DATA_W-LEN_W){1'b0}}, s.len});
			cfg_if.valid <= 1'b0;
			req_idle_on = s.idle;
			rsp_idle_on = s.idle;
			live_runs.delete();
			if (p == 0)
				free_run(32'd0, 256);
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end)
				random_word();
		end

		settle();
		repeat (150) @(posedge clk);
		$display("%0d request words over %0d map settings, reset map included", words_sent,
			PHASES + 1);
		$display("replies: %0d ok, %0d no free run, %0d out of range", n_granted, n_refused,
			n_range);
		if (bad_count == 0) begin
			$display("tb_bitmap_run_allocator: done, clean");
		end else begin
			$display("%0d mismatches", bad_count);
			$display("tb_bitmap_run_allocator: done, errors");
		end
		$finish;
	end

endmodule
